// ----- hdl/fqd_pkg.sv -----
`timescale 1ns / 1ps

package fqd_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int ITEM_WIDTH_DEF = 32;
   localparam int CMD_W          = 2;
   localparam int ITEM_PORT_W    = 32;
   localparam int COUNT_PORT_W   = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ = 2'd0,
      CMD_DEQ = 2'd1,
      CMD_DEL = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DEQ_WAIT,
      ST_SEARCH,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

// ----- hdl/fqd_ram.sv -----
`timescale 1ns / 1ps

module fqd_ram #(
   parameter int DEPTH = fqd_pkg::DEPTH_DEF,
   parameter int WIDTH = fqd_pkg::ITEM_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fifo_queue_with_delete.sv -----
`timescale 1ns / 1ps
// Enqueue and unused codes go from execute straight to the response state; dequeue passes
//   through a wait state for the memory read (skipped when the queue is empty).
// Delete scans from the head, one memory access a cycle, until a match, then moves every entry
//   behind the match up by one slot; a miss scans all entries held.
// One request at a time; a new request is taken while the response register still waits.
// Reset empties the queue; the entry memory is not cleared.
module fifo_queue_with_delete #(
   parameter int DEPTH      = fqd_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = fqd_pkg::ITEM_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fqd_pkg::CMD_W-1:0]        req_cmd,
   input  logic [fqd_pkg::ITEM_PORT_W-1:0]  req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic [fqd_pkg::ITEM_PORT_W-1:0]  rsp_item_out,
   output logic [fqd_pkg::COUNT_PORT_W-1:0] rsp_count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMD_BITS = fqd_pkg::CMD_W;

   fqd_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic [CNT_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      wr_idx_ff, wr_idx_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [CNT_W-1:0]      j_next;

   logic [CMD_BITS-1:0]   cmd_ff;
   logic [ITEM_WIDTH-1:0] item_ff;
   logic                  res_ok_ff, res_ok_in;
   logic [fqd_pkg::ITEM_PORT_W-1:0] res_item_ff, res_item_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic                  rsp_ok_ff;
   logic [fqd_pkg::ITEM_PORT_W-1:0]  rsp_item_out_ff;
   logic [fqd_pkg::COUNT_PORT_W-1:0] rsp_count_ff;

   logic                  mem_rd_en;
   logic [PTR_W-1:0]      mem_rd_addr;
   logic [ITEM_WIDTH-1:0] mem_rd_data;
   logic                  mem_wr_en;
   logic [PTR_W-1:0]      mem_wr_addr;
   logic [ITEM_WIDTH-1:0] mem_wr_data;

   logic                  accept;
   logic                  has_room;
   logic                  match;
   logic                  scan_more;
   logic                  shift_more;

   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] n);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(n);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   fqd_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ITEM_WIDTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign req_ready  = (state_ff == fqd_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign has_room   = (count_ff < CNT_W'(DEPTH));
   assign match      = cmp_valid_ff && (mem_rd_data == item_ff);
   assign scan_more  = (issue_ff < count_ff);
   assign j_next     = j_ff + CNT_W'(1);
   assign shift_more = (j_next < count_ff);
   assign rsp_load   = (state_ff == fqd_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fqd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fqd_pkg::ST_EXEC;
            end
         end
         fqd_pkg::ST_EXEC: begin
            unique case (cmd_ff)
               fqd_pkg::CMD_DEQ: begin
                  state_in = (count_ff != '0) ? fqd_pkg::ST_DEQ_WAIT : fqd_pkg::ST_RESP;
               end
               fqd_pkg::CMD_DEL: state_in = fqd_pkg::ST_SEARCH;
               default:          state_in = fqd_pkg::ST_RESP;
            endcase
         end
         fqd_pkg::ST_DEQ_WAIT: state_in = fqd_pkg::ST_RESP;
         fqd_pkg::ST_SEARCH: begin
            if (match) begin
               state_in = fqd_pkg::ST_SHIFT;
            end else if (!scan_more && !cmp_valid_ff) begin
               state_in = fqd_pkg::ST_RESP;
            end
         end
         fqd_pkg::ST_SHIFT: begin
            if (!shift_more && !wr_pend_ff) begin
               state_in = fqd_pkg::ST_RESP;
            end
         end
         fqd_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = fqd_pkg::ST_IDLE;
            end
         end
         default: state_in = fqd_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      issue_in     = issue_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      j_in         = j_ff;
      wr_idx_in    = wr_idx_ff;
      wr_pend_in   = wr_pend_ff;
      res_ok_in    = res_ok_ff;
      res_item_in  = res_item_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = head_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_of(head_ff, wr_idx_ff);
      mem_wr_data  = mem_rd_data;
      unique case (state_ff)
         fqd_pkg::ST_EXEC: begin
            res_ok_in   = 1'b0;
            res_item_in = '0;
            unique case (cmd_ff)
               fqd_pkg::CMD_ENQ: begin
                  if (has_room) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = slot_of(head_ff, count_ff);
                     mem_wr_data = item_ff;
                     count_in    = count_ff + CNT_W'(1);
                     res_ok_in   = 1'b1;
                  end
               end
               fqd_pkg::CMD_DEQ: begin
                  mem_rd_en = (count_ff != '0);
               end
               fqd_pkg::CMD_DEL: begin
                  issue_in     = '0;
                  cmp_valid_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         fqd_pkg::ST_DEQ_WAIT: begin
            res_ok_in   = 1'b1;
            res_item_in = fqd_pkg::ITEM_PORT_W'(mem_rd_data);
            head_in     = slot_of(head_ff, CNT_W'(1));
            count_in    = count_ff - CNT_W'(1);
         end
         fqd_pkg::ST_SEARCH: begin
            if (match) begin
               j_in       = cmp_idx_ff;
               wr_pend_in = 1'b0;
            end else if (scan_more) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = slot_of(head_ff, issue_ff);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff;
               issue_in     = issue_ff + CNT_W'(1);
            end else begin
               cmp_valid_in = 1'b0;
            end
         end
         fqd_pkg::ST_SHIFT: begin
            mem_wr_en = wr_pend_ff;
            if (shift_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_of(head_ff, j_next);
               wr_pend_in  = 1'b1;
               wr_idx_in   = j_ff;
               j_in        = j_next;
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  count_in  = count_ff - CNT_W'(1);
                  res_ok_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fqd_pkg::ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         cmp_valid_ff <= cmp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         item_ff <= ITEM_WIDTH'(req_item);
      end
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      j_ff        <= j_in;
      wr_idx_ff   <= wr_idx_in;
      res_ok_ff   <= res_ok_in;
      res_item_ff <= res_item_in;
      if (rsp_load) begin
         rsp_ok_ff       <= res_ok_ff;
         rsp_item_out_ff <= res_item_ff;
         rsp_count_ff    <= fqd_pkg::COUNT_PORT_W'(count_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_item_out = rsp_item_out_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// ----- hdl/fqd_checker.sv -----
`timescale 1ns / 1ps

module fqd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [fqd_pkg::CMD_W-1:0]        req_cmd,
   input logic [fqd_pkg::ITEM_PORT_W-1:0]  req_item,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_ok,
   input logic [fqd_pkg::ITEM_PORT_W-1:0]  rsp_item_out,
   input logic [fqd_pkg::COUNT_PORT_W-1:0] rsp_count
);

   // a failed request never carries an item
   a_fail_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_item_out == '0)
      else $error("failed response carries an item");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
                                  && $stable(rsp_item_out) && $stable(rsp_count))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending after reset");

endmodule

bind fifo_queue_with_delete fqd_checker u_checker (.*);

// ----- dv/fqd_queue_checker.sv -----
`timescale 1ns / 1ps

module fqd_queue_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [fqd_pkg::CMD_W-1:0]        req_cmd,
   input  logic [fqd_pkg::ITEM_PORT_W-1:0]  req_item,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_ok,
   input  logic [fqd_pkg::ITEM_PORT_W-1:0]  rsp_item_out,
   input  logic [fqd_pkg::COUNT_PORT_W-1:0] rsp_count,
   output int                               mismatch_count,
   output int                               awaited_count
);

   typedef struct packed {
      logic                             ok;
      logic [fqd_pkg::ITEM_PORT_W-1:0]  item_out;
      logic [fqd_pkg::COUNT_PORT_W-1:0] count;
   } queue_result_type;

   logic [fqd_pkg::ITEM_PORT_W-1:0] held_words[$];
   queue_result_type                awaited_results[$];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   function automatic queue_result_type apply_command(
      input logic [fqd_pkg::CMD_W-1:0]       cmd,
      input logic [fqd_pkg::ITEM_PORT_W-1:0] word);
      queue_result_type outcome;
      int               match_at;
      outcome  = '0;
      match_at = -1;
      case (cmd)
         fqd_pkg::CMD_ENQ: begin
            if (held_words.size() < fqd_pkg::DEPTH_DEF) begin
               held_words.push_back(word);
               outcome.ok = 1'b1;
            end
         end
         fqd_pkg::CMD_DEQ: begin
            if (held_words.size() > 0) begin
               outcome.item_out = held_words.pop_front();
               outcome.ok       = 1'b1;
            end
         end
         fqd_pkg::CMD_DEL: begin
            // remove only the oldest match
            for (int i = 0; i < held_words.size(); i++) begin
               if (match_at < 0 && held_words[i] == word) match_at = i;
            end
            if (match_at >= 0) begin
               held_words.delete(match_at);
               outcome.ok = 1'b1;
            end
         end
         default: ;
      endcase
      outcome.count = fqd_pkg::COUNT_PORT_W'(held_words.size());
      return outcome;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_words.delete();
         awaited_results.delete();
         awaited_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("response with no request waiting: ok %0d item_out %h count %0d",
                      rsp_ok, rsp_item_out, rsp_count);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
                  mismatch_count++;
               end
               if (rsp_item_out !== want.item_out) begin
                  $error("rsp_item_out: expected %h, got %h", want.item_out, rsp_item_out);
                  mismatch_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("rsp_count: expected %0d, got %0d", want.count, rsp_count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_results.push_back(apply_command(req_cmd, req_item));
         end
         awaited_count <= awaited_results.size();
      end
   end

endmodule

// ----- dv/fifo_queue_with_delete_tb.sv -----
`timescale 1ns / 1ps

module fifo_queue_with_delete_tb;

   localparam logic [fqd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int PHASE_FILL   = 0;
   localparam int PHASE_DRAIN  = 1;
   localparam int PHASE_ITEMS  = 200;
   localparam int PHASE_TOTAL  = 7;
   localparam int HOLD_CYCLES  = 150;
   localparam int RECENT_DEPTH = 16;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic [fqd_pkg::CMD_W-1:0]         req_cmd   = fqd_pkg::CMD_ENQ;
   logic [fqd_pkg::ITEM_PORT_W-1:0]   req_item  = '0;
   logic                              rsp_ready = 1'b0;
   logic                              req_ready;
   logic                              rsp_valid;
   logic                              rsp_ok;
   logic [fqd_pkg::ITEM_PORT_W-1:0]   rsp_item_out;
   logic [fqd_pkg::COUNT_PORT_W-1:0]  rsp_count;
   int                                mismatch_count;
   int                                awaited_count;

   bit                                steady_phase = 1'b0;
   bit                                hold_rsp     = 1'b0;
   logic [fqd_pkg::ITEM_PORT_W-1:0]   word_pool[8];
   logic [fqd_pkg::ITEM_PORT_W-1:0]   recent_words[$];

   always #5 clock = ~clock;

   fifo_queue_with_delete DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ok       (rsp_ok),
      .rsp_item_out (rsp_item_out),
      .rsp_count    (rsp_count)
   );

   fqd_queue_checker queue_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_item_out   (rsp_item_out),
      .rsp_count      (rsp_count),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   function automatic int idle_cycles();
      return steady_phase ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [fqd_pkg::CMD_W-1:0] pick_command(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return CMD_UNUSED;
      case (mode)
         PHASE_FILL:  return (roll < 72) ? fqd_pkg::CMD_ENQ :
                             (roll < 86) ? fqd_pkg::CMD_DEQ : fqd_pkg::CMD_DEL;
         PHASE_DRAIN: return (roll < 20) ? fqd_pkg::CMD_ENQ :
                             (roll < 70) ? fqd_pkg::CMD_DEQ : fqd_pkg::CMD_DEL;
         default:     return (roll < 45) ? fqd_pkg::CMD_ENQ :
                             (roll < 75) ? fqd_pkg::CMD_DEQ : fqd_pkg::CMD_DEL;
      endcase
   endfunction

   function automatic logic [fqd_pkg::ITEM_PORT_W-1:0] pick_word(
      input logic [fqd_pkg::CMD_W-1:0] cmd);
      int roll;
      roll = $urandom_range(0, 9);
      if (cmd == fqd_pkg::CMD_DEL && roll < 5 && recent_words.size() > 0)
         return recent_words[$urandom_range(0, recent_words.size() - 1)];
      if (roll < 6) return word_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic send_request(input logic [fqd_pkg::CMD_W-1:0]       cmd,
                               input logic [fqd_pkg::ITEM_PORT_W-1:0] word);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_item  <= word;
      do @(posedge clock); while (!req_ready);
      if (cmd == fqd_pkg::CMD_ENQ) begin
         recent_words.push_back(word);
         if (recent_words.size() > RECENT_DEPTH) void'(recent_words.pop_front());
      end
   endtask

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, one long hold when asked
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap      = hold_rsp ? HOLD_CYCLES : idle_cycles();
         hold_rsp = 1'b0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [fqd_pkg::CMD_W-1:0] cmd;
      word_pool[0] = '0;
      word_pool[1] = '1;
      for (int i = 2; i < 8; i++) word_pool[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(fqd_pkg::CMD_DEQ, 32'h1234_5678);
      send_request(fqd_pkg::CMD_DEL, 32'h0000_0000);
      send_request(CMD_UNUSED, 32'hFFFF_FFFF);
      send_request(fqd_pkg::CMD_ENQ, 32'h0000_0000);
      send_request(fqd_pkg::CMD_ENQ, 32'hFFFF_FFFF);
      send_request(fqd_pkg::CMD_ENQ, 32'h5555_AAAA);
      send_request(fqd_pkg::CMD_ENQ, 32'h0000_0000);
      send_request(fqd_pkg::CMD_ENQ, 32'hAAAA_5555);
      send_request(fqd_pkg::CMD_DEL, 32'h0000_0000);
      send_request(fqd_pkg::CMD_DEL, 32'h1234_5678);
      send_request(fqd_pkg::CMD_DEL, 32'hAAAA_5555);
      send_request(fqd_pkg::CMD_DEL, 32'hFFFF_FFFF);
      send_request(CMD_UNUSED, 32'h0000_0001);
      send_request(fqd_pkg::CMD_DEQ, 32'hFFFF_FFFF);
      send_request(fqd_pkg::CMD_DEQ, 32'h0000_0000);
      send_request(fqd_pkg::CMD_DEQ, 32'h0000_0000);

      for (int phase = 0; phase < PHASE_TOTAL; phase++) begin
         steady_phase = (phase == 3);
         if (phase == 1) hold_rsp = 1'b1;
         if (phase == 5) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (awaited_count != 0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = pick_command(phase % 3);
            send_request(cmd, pick_word(cmd));
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (awaited_count != 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
